FILE: hdl/htl_pkg.sv
// htl_pkg: token kinds, lexer modes, error codes and the keyword rom for the html tag lexer
// no dependencies
`default_nettype none
package htl_pkg;

   localparam int ROM_SIZE  = 120;
   localparam int ROM_CHARS = 15;

   localparam logic [3:0] K_EOF   = 4'd0;
   localparam logic [3:0] K_LT    = 4'd1;
   localparam logic [3:0] K_GT    = 4'd2;
   localparam logic [3:0] K_EQ    = 4'd3;
   localparam logic [3:0] K_SLASH = 4'd4;
   localparam logic [3:0] K_SCHAR = 4'd5;
   localparam logic [3:0] K_SEND  = 4'd6;
   localparam logic [3:0] K_KW    = 4'd7;
   localparam logic [3:0] K_CHAR  = 4'd8;
   localparam logic [3:0] K_ERR   = 4'd9;

   localparam logic [2:0] M_NORMAL   = 3'd0;
   localparam logic [2:0] M_AFTER_LT = 3'd1;
   localparam logic [2:0] M_WORD     = 3'd2;
   localparam logic [2:0] M_STRING   = 3'd3;
   localparam logic [2:0] M_CMT0     = 3'd4;
   localparam logic [2:0] M_CMT1     = 3'd5;
   localparam logic [2:0] M_CMT2     = 3'd6;
   localparam logic [2:0] M_HALT     = 3'd7;

   localparam logic [1:0] E_NONE    = 2'd0;
   localparam logic [1:0] E_STRING  = 2'd1;
   localparam logic [1:0] E_WORD    = 2'd2;
   localparam logic [1:0] E_COMMENT = 2'd3;

   localparam logic [7:0] CH_LT    = 8'h3c;
   localparam logic [7:0] CH_GT    = 8'h3e;
   localparam logic [7:0] CH_EQ    = 8'h3d;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_DASH  = 8'h2d;

   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] ch;
      logic [6:0] kw;
      logic [1:0] ec;
      logic       last;
   } token_type;

   // word end request from front to back: the word plus up to two plain tokens
   typedef struct packed {
      logic                     has_word;
      logic [ROM_CHARS*8-1:0]   word;      // byte 0 in low bits, zero padded
      logic                     word_bad;  // too long or empty
      logic [1:0]               n_after;   // tokens after the word (or only tokens)
      token_type                t0;
      token_type                t1;
      logic                     drop_t_on_miss;
   } job_type;

   function automatic logic [ROM_CHARS*8-1:0] kw_pack(input string s);
      logic [ROM_CHARS*8-1:0] v;
      v = '0;
      for (int i = 0; i < ROM_CHARS; i++)
         if (i < s.len())
            v[i*8 +: 8] = s[i];
      return v;
   endfunction

   function automatic logic [ROM_CHARS*8-1:0] kw_rom(input int idx);
      logic [ROM_CHARS*8-1:0] v;
      v = '0;
      case (idx)
         0: v = kw_pack("download");    1: v = kw_pack("hreflang");
         2: v = kw_pack("media");       3: v = kw_pack("ping");
         4: v = kw_pack("referrerpolicy"); 5: v = kw_pack("rel");
         6: v = kw_pack("target");      7: v = kw_pack("type");
         8: v = kw_pack("xmlns");       9: v = kw_pack("accesskey");
         10: v = kw_pack("lang");       11: v = kw_pack("autocapitalize");
         12: v = kw_pack("href");       13: v = kw_pack("abbr");
         14: v = kw_pack("a");          15: v = kw_pack("body");
         16: v = kw_pack("bold");       17: v = kw_pack("div");
         18: v = kw_pack("html");       19: v = kw_pack("p");
         20: v = kw_pack("table");      21: v = kw_pack("area");
         22: v = kw_pack("article");    23: v = kw_pack("aside");
         24: v = kw_pack("audio");      25: v = kw_pack("b");
         26: v = kw_pack("base");       27: v = kw_pack("bdi");
         28: v = kw_pack("bdo");        29: v = kw_pack("blockquote");
         30: v = kw_pack("br");         31: v = kw_pack("button");
         32: v = kw_pack("canvas");     33: v = kw_pack("caption");
         34: v = kw_pack("cite");       35: v = kw_pack("code");
         36: v = kw_pack("col");        37: v = kw_pack("colgroup");
         38: v = kw_pack("data");       39: v = kw_pack("datalist");
         40: v = kw_pack("dd");         41: v = kw_pack("del");
         42: v = kw_pack("details");    43: v = kw_pack("dfn");
         44: v = kw_pack("dialog");     45: v = kw_pack("dl");
         46: v = kw_pack("dt");         47: v = kw_pack("em");
         48: v = kw_pack("embed");      49: v = kw_pack("fieldset");
         50: v = kw_pack("figcaption"); 51: v = kw_pack("figure");
         52: v = kw_pack("footer");     53: v = kw_pack("form");
         54: v = kw_pack("h1");         55: v = kw_pack("head");
         56: v = kw_pack("header");     57: v = kw_pack("hgroup");
         58: v = kw_pack("hr");         59: v = kw_pack("i");
         60: v = kw_pack("iframe");     61: v = kw_pack("img");
         62: v = kw_pack("input");      63: v = kw_pack("ins");
         64: v = kw_pack("kbd");        65: v = kw_pack("label");
         66: v = kw_pack("legend");     67: v = kw_pack("li");
         68: v = kw_pack("link");       69: v = kw_pack("main");
         70: v = kw_pack("map");        71: v = kw_pack("mark");
         72: v = kw_pack("menu");       73: v = kw_pack("meta");
         74: v = kw_pack("meter");      75: v = kw_pack("nav");
         76: v = kw_pack("noscript");   77: v = kw_pack("object");
         78: v = kw_pack("ol");         79: v = kw_pack("optgroup");
         80: v = kw_pack("option");     81: v = kw_pack("output");
         82: v = kw_pack("picture");    83: v = kw_pack("pre");
         84: v = kw_pack("progress");   85: v = kw_pack("q");
         86: v = kw_pack("rp");         87: v = kw_pack("rt");
         88: v = kw_pack("ruby");       89: v = kw_pack("s");
         90: v = kw_pack("samp");       91: v = kw_pack("script");
         92: v = kw_pack("search");     93: v = kw_pack("section");
         94: v = kw_pack("select");     95: v = kw_pack("slot");
         96: v = kw_pack("small");      97: v = kw_pack("source");
         98: v = kw_pack("span");       99: v = kw_pack("strong");
         100: v = kw_pack("style");     101: v = kw_pack("sub");
         102: v = kw_pack("summary");   103: v = kw_pack("sup");
         104: v = kw_pack("tbody");     105: v = kw_pack("td");
         106: v = kw_pack("template");  107: v = kw_pack("textarea");
         108: v = kw_pack("tfoot");     109: v = kw_pack("th");
         110: v = kw_pack("thead");     111: v = kw_pack("time");
         112: v = kw_pack("title");     113: v = kw_pack("tr");
         114: v = kw_pack("track");     115: v = kw_pack("u");
         116: v = kw_pack("ul");        117: v = kw_pack("var");
         118: v = kw_pack("video");     119: v = kw_pack("wbr");
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/htl_front.sv
// htl_front: byte classifier and lexer mode machine; collects words and builds jobs
// depends on htl_pkg
`default_nettype none
module htl_front
   import htl_pkg::*;
#(
   parameter int MAX_WORD_LEN = 14
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   input  wire logic [7:0] in_byte,
   input  wire logic       in_end,
   output logic            in_ready,
   output logic            job_valid,
   output job_type         job,
   input  wire logic       job_ready,
   input  wire logic       halt
);

   localparam int LW = $clog2(MAX_WORD_LEN + 1);
   localparam int IW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;

   logic [2:0]    mode_ff, mode_in;
   logic          tag_ff, tag_in;
   logic [LW-1:0] len_ff, len_in;
   logic          long_ff, long_in;
   logic [7:0]    chars_ff [MAX_WORD_LEN];
   logic          wr_en;
   logic [IW-1:0] wr_idx;
   logic [7:0]    wr_data;

   logic [1:0] ntok;
   token_type  t0, t1;
   logic       fire, emit_word;

   function automatic token_type mk(input logic [3:0] k, input logic [7:0] c,
                                    input logic [1:0] e);
      token_type t;
      t = '{kind: k, ch: c, kw: 7'd0, ec: e, last: 1'b0};
      return t;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
   endfunction

   assign in_ready = job_ready;
   assign fire     = in_valid && in_ready;

   // halt from the back end arrives after the error job; later items give nothing
   always_comb begin
      logic [2:0] fm;
      logic       ft;
      logic       fresh;
      logic [7:0] c;
      mode_in   = mode_ff;
      tag_in    = tag_ff;
      len_in    = len_ff;
      long_in   = long_ff;
      wr_en     = 1'b0;
      wr_idx    = '0;
      wr_data   = in_byte;
      ntok      = 2'd0;
      t0        = mk(K_EOF, 8'd0, E_NONE);
      t1        = mk(K_EOF, 8'd0, E_NONE);
      emit_word = 1'b0;
      fresh     = 1'b0;
      fm        = M_NORMAL;
      ft        = tag_ff;
      c         = in_byte;
      if (in_end) begin
         case (mode_ff)
            M_HALT: ;
            M_AFTER_LT: begin
               ntok = 2'd2; t0 = mk(K_LT, 8'd0, E_NONE); t1 = mk(K_EOF, 8'd0, E_NONE);
               mode_in = M_NORMAL; tag_in = 1'b0;
            end
            M_WORD: begin
               emit_word = 1'b1; ntok = 2'd1; t0 = mk(K_EOF, 8'd0, E_NONE);
               mode_in = M_NORMAL; tag_in = 1'b0;
            end
            M_STRING: begin
               ntok = 2'd1; t0 = mk(K_ERR, 8'd0, E_STRING); mode_in = M_HALT;
            end
            M_CMT0, M_CMT1, M_CMT2: begin
               ntok = 2'd1; t0 = mk(K_ERR, 8'd0, E_COMMENT); mode_in = M_HALT;
            end
            default: begin
               ntok = 2'd1; t0 = mk(K_EOF, 8'd0, E_NONE);
               mode_in = M_NORMAL; tag_in = 1'b0;
            end
         endcase
      end else begin
         case (mode_ff)
            M_HALT: ;
            M_AFTER_LT: begin
               if (c == CH_BANG) begin
                  mode_in = M_CMT0;
               end else begin
                  ntok = 2'd1; t0 = mk(K_LT, 8'd0, E_NONE);
                  fresh = 1'b1; ft = 1'b1;
               end
            end
            M_WORD: begin
               if (is_letter(c)) begin
                  if (len_ff < LW'(MAX_WORD_LEN)) begin
                     wr_en = 1'b1; wr_idx = IW'(len_ff); len_in = len_ff + 1'b1;
                  end else begin
                     long_in = 1'b1;
                  end
               end else begin
                  emit_word = 1'b1; fresh = 1'b1;
               end
            end
            M_STRING: begin
               ntok = 2'd1;
               if (c == CH_QUOTE) begin
                  t0 = mk(K_SEND, 8'd0, E_NONE); mode_in = M_NORMAL;
               end else begin
                  t0 = mk(K_SCHAR, c, E_NONE);
               end
            end
            M_CMT0: if (c == CH_DASH) mode_in = M_CMT1;
            M_CMT1: mode_in = (c == CH_DASH) ? M_CMT2 : M_CMT0;
            M_CMT2: mode_in = (c == CH_GT) ? M_NORMAL : M_CMT0;
            default: fresh = 1'b1;
         endcase
         if (fresh) begin
            tag_in = ft;
            fm     = M_NORMAL;
            if (ft && is_space(c)) begin
               fm = M_NORMAL;
            end else if (c == CH_LT) begin
               fm = M_AFTER_LT;
            end else if (c == CH_GT) begin
               t1 = mk(K_GT, 8'd0, E_NONE); ntok = ntok + 1'b1; tag_in = 1'b0;
            end else if (c == CH_EQ) begin
               t1 = mk(K_EQ, 8'd0, E_NONE); ntok = ntok + 1'b1;
            end else if (c == CH_SLASH) begin
               t1 = mk(K_SLASH, 8'd0, E_NONE); ntok = ntok + 1'b1;
            end else if (c == CH_QUOTE) begin
               fm = M_STRING;
            end else if (ft && is_letter(c)) begin
               fm = M_WORD; wr_en = 1'b1; wr_idx = '0;
               len_in = LW'(1); long_in = 1'b0;
            end else begin
               t1 = mk(K_CHAR, c, E_NONE); ntok = ntok + 1'b1;
            end
            if (ntok == 2'd1 && mode_ff != M_AFTER_LT) t0 = t1;
            mode_in = fm;
         end
      end
   end

   always_comb begin
      job = '0;
      job.has_word       = emit_word;
      job.word_bad       = long_ff || (len_ff == '0);
      job.n_after        = ntok;
      job.t0             = t0;
      job.t1             = t1;
      job.drop_t_on_miss = 1'b1;
      for (int i = 0; i < MAX_WORD_LEN && i < ROM_CHARS; i++)
         if (LW'(i) < len_ff)
            job.word[i*8 +: 8] = chars_ff[i];
      if (MAX_WORD_LEN >= ROM_CHARS && len_ff >= LW'(ROM_CHARS))
         job.word_bad = 1'b1;
   end

   assign job_valid = fire && !halt && (emit_word || ntok != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_NORMAL;
         tag_ff  <= 1'b0;
         len_ff  <= '0;
         long_ff <= 1'b0;
      end else if (fire && !halt) begin
         mode_ff <= (emit_word && !in_end && mode_in == M_NORMAL) ? M_NORMAL : mode_in;
         tag_ff  <= tag_in;
         len_ff  <= len_in;
         long_ff <= long_in;
      end
      if (fire && !halt && wr_en)
         chars_ff[wr_idx] <= wr_data;
   end

`ifndef NO_ASSERTIONS
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LW'(MAX_WORD_LEN)) else $error("word length past limit");
   a_job_fire: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> fire) else $error("job without accepted item");
   a_word_mode: assert property (@(posedge clock) disable iff (reset)
      (job_valid && job.has_word) |-> mode_ff == M_WORD)
      else $error("word job outside word mode");
`endif

endmodule
`default_nettype wire

FILE: hdl/htl_back.sv
// htl_back: job queue, keyword rom match and token output queue
// depends on htl_pkg
`default_nettype none
module htl_back
   import htl_pkg::*;
#(
   parameter int KEYWORD_COUNT = 120
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic job_valid,
   input  job_type   job,
   output logic      job_ready,
   output logic      halt,
   output logic      out_valid,
   output token_type out_tok,
   input  wire logic out_pop
);

   localparam int NKW = (KEYWORD_COUNT < ROM_SIZE) ? KEYWORD_COUNT : ROM_SIZE;
   localparam int QD  = 4;

   // job queue between front and match stage
   job_type    jq_ff [2];
   logic [1:0] jcnt_ff;
   logic       jrd_ff, jwr_ff;

   // token queue: each slot holds one token
   token_type  tq_ff [QD];
   logic [1:0] trd_ff, twr_ff;
   logic [2:0] tcnt_ff;

   logic       halt_ff;
   job_type    hj;
   logic       take;
   logic       miss;
   logic       hit;
   logic [6:0] hit_idx;
   token_type  o0, o1, o2;
   logic [1:0] nout;
   logic       pop;

   assign hj = jq_ff[jrd_ff];

   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = NKW - 1; i >= 0; i--)
         if (kw_rom(i) == hj.word) begin
            hit = 1'b1; hit_idx = 7'(i);
         end
      if (hj.word_bad) hit = 1'b0;
   end

   always_comb begin
      token_type kt;
      kt   = '{kind: K_KW, ch: 8'd0, kw: hit_idx, ec: E_NONE, last: 1'b0};
      o0   = hj.t0; o1 = hj.t1; o2 = hj.t1;
      nout = hj.n_after;
      if (hj.has_word) begin
         if (hit) begin
            o0   = kt; o1 = hj.t0;
            nout = hj.n_after + 2'd1;
         end else begin
            o0   = '{kind: K_ERR, ch: 8'd0, kw: 7'd0, ec: E_WORD, last: 1'b0};
            nout = 2'd1;
         end
      end
      if (nout == 2'd1) o0.last = 1'b1;
      else o1.last = 1'b1;
   end

   assign pop       = out_pop && out_valid;
   assign take      = (jcnt_ff != 2'd0) && (tcnt_ff <= 3'(QD - 2));
   assign miss      = take && hj.has_word && !hit;
   assign job_ready = (jcnt_ff != 2'd2) && !halt_ff;
   assign halt      = halt_ff;
   assign out_valid = tcnt_ff != 3'd0;
   assign out_tok   = tq_ff[trd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         jcnt_ff <= '0; jrd_ff <= 1'b0; jwr_ff <= 1'b0;
         trd_ff  <= '0; twr_ff <= '0;   tcnt_ff <= '0;
         halt_ff <= 1'b0;
      end else begin
         if (miss) begin
            // unknown word halts the lexer: jobs queued behind it are dropped
            jcnt_ff <= '0; jrd_ff <= 1'b0; jwr_ff <= 1'b0;
            halt_ff <= 1'b1;
         end else begin
            if (job_valid && job_ready) begin
               jwr_ff <= !jwr_ff;
               if (job.t0.kind == K_ERR && !job.has_word) halt_ff <= 1'b1;
            end
            if (take) jrd_ff <= !jrd_ff;
            jcnt_ff <= jcnt_ff + 2'(job_valid && job_ready) - 2'(take);
         end
         twr_ff  <= twr_ff + (take ? nout : 2'd0);
         trd_ff  <= trd_ff + 2'(pop);
         tcnt_ff <= tcnt_ff + (take ? 3'(nout) : 3'd0) - 3'(pop);
      end
      if (job_valid && job_ready) jq_ff[jwr_ff] <= job;
      if (take) begin
         tq_ff[twr_ff] <= o0;
         if (nout == 2'd2) tq_ff[twr_ff + 2'd1] <= o1;
      end
   end

`ifndef NO_ASSERTIONS
   a_tq_bound: assert property (@(posedge clock) disable iff (reset)
      tcnt_ff <= 3'(QD)) else $error("token queue overflow");
   a_jq_bound: assert property (@(posedge clock) disable iff (reset)
      jcnt_ff <= 2'd2) else $error("job queue overflow");
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff) else $error("halt cleared without reset");
`endif

endmodule
`default_nettype wire

FILE: hdl/html_tag_lexer.sv
// html_tag_lexer: top level, joins the byte front end to the match and output back end
// depends on htl_pkg, htl_front, htl_back
//
// Usage: bytes (or an end mark) are pushed while full is low; tokens are
// popped while empty is low. Each byte gives zero, one or two tokens, the
// last flagged by rsp_last_of_run. One byte is taken per cycle while full is low.
// A token reaches the result ports through the job queue and then the token
// queue, and the held word is compared against every rom entry in parallel
// on its way into the token queue. A two-entry job queue and four-entry
// token queue decouple the ends; when the receiver stops popping, the token
// queue fills, then the job queue, and full rises. Reset clears all modes
// and queues. After an error token the block takes and drops every further
// item until reset.
`default_nettype none
module html_tag_lexer
   import htl_pkg::*;
#(
   parameter int MAX_WORD_LEN  = 14,
   parameter int KEYWORD_COUNT = 120
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   output logic            full,
   input  wire logic [7:0] req_input_byte,
   input  wire logic       req_end_of_input,
   output logic            empty,
   input  wire logic       pop,
   output logic [3:0]      rsp_token_kind,
   output logic [7:0]      rsp_char_value,
   output logic [6:0]      rsp_keyword_index,
   output logic [1:0]      rsp_error_code,
   output logic            rsp_last_of_run
);

   job_type   job;
   logic      job_valid, job_ready, in_ready, halt, out_valid;
   token_type tok;

   htl_front #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_front (
      .clock, .reset,
      .in_valid(push), .in_byte(req_input_byte), .in_end(req_end_of_input),
      .in_ready, .job_valid, .job, .job_ready, .halt
   );

   htl_back #(.KEYWORD_COUNT(KEYWORD_COUNT)) u_back (
      .clock, .reset, .job_valid, .job, .job_ready, .halt,
      .out_valid, .out_tok(tok), .out_pop(pop)
   );

   assign full              = !in_ready && !halt;
   assign empty             = !out_valid;
   assign rsp_token_kind    = tok.kind;
   assign rsp_char_value    = tok.ch;
   assign rsp_keyword_index = tok.kw;
   assign rsp_error_code    = tok.ec;
   assign rsp_last_of_run   = tok.last;

endmodule
`default_nettype wire

FILE: test/tb_top.sv
// tb_top: self-checking bench for html_tag_lexer, predicts tokens per byte and compares
// depends on htl_pkg and the html_tag_lexer rtl
`default_nettype none
module tb_top;
   import htl_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WORD_MAX = 14;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       push = 1'b0;
   logic       full;
   logic [7:0] req_input_byte = 8'd0;
   logic       req_end_of_input = 1'b0;
   logic       empty;
   logic       pop = 1'b0;
   logic [3:0] rsp_token_kind;
   logic [7:0] rsp_char_value;
   logic [6:0] rsp_keyword_index;
   logic [1:0] rsp_error_code;
   logic       rsp_last_of_run;

   html_tag_lexer u_top (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_input_byte(req_input_byte), .req_end_of_input(req_end_of_input),
      .empty(empty), .pop(pop), .rsp_token_kind(rsp_token_kind),
      .rsp_char_value(rsp_char_value), .rsp_keyword_index(rsp_keyword_index),
      .rsp_error_code(rsp_error_code), .rsp_last_of_run(rsp_last_of_run)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // keyword table kept as strings, in rom order
   string kw_names[120] = '{
      "download", "hreflang", "media", "ping", "referrerpolicy", "rel",
      "target", "type", "xmlns", "accesskey", "lang", "autocapitalize",
      "href", "abbr", "a", "body", "bold", "div", "html", "p", "table",
      "area", "article", "aside", "audio", "b", "base", "bdi", "bdo",
      "blockquote", "br", "button", "canvas", "caption", "cite", "code",
      "col", "colgroup", "data", "datalist", "dd", "del", "details", "dfn",
      "dialog", "dl", "dt", "em", "embed", "fieldset", "figcaption",
      "figure", "footer", "form", "h1", "head", "header", "hgroup", "hr",
      "i", "iframe", "img", "input", "ins", "kbd", "label", "legend", "li",
      "link", "main", "map", "mark", "menu", "meta", "meter", "nav",
      "noscript", "object", "ol", "optgroup", "option", "output", "picture",
      "pre", "progress", "q", "rp", "rt", "ruby", "s", "samp", "script",
      "search", "section", "select", "slot", "small", "source", "span",
      "strong", "style", "sub", "summary", "sup", "tbody", "td", "template",
      "textarea", "tfoot", "th", "thead", "time", "title", "tr", "track",
      "u", "ul", "var", "video", "wbr"};

   // lexer state mirror
   logic [2:0] mode;
   logic       tag_open;
   string      word;
   logic       word_long;
   token_type  token_queue[$];
   token_type  step_toks[$];
   int         mismatches = 0;
   int         tokens_seen = 0;
   int         items_sent = 0;
   bit         idle_on = 1'b1;
   bit         stim_done = 1'b0;

   function automatic bit is_ws(logic [7:0] c);
      return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic bit is_alpha(logic [7:0] c);
      return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
   endfunction

   function automatic void add_tok(logic [3:0] k, logic [7:0] c, logic [6:0] w,
                                   logic [1:0] e);
      token_type t;
      t.kind = k; t.ch = c; t.kw = w; t.ec = e; t.last = 1'b0;
      step_toks.push_back(t);
   endfunction

   function automatic void halt_with(logic [1:0] e);
      add_tok(K_ERR, 8'd0, 7'd0, e);
      mode = M_HALT;
   endfunction

   function automatic void lex_plain(logic [7:0] c);
      if (tag_open && is_ws(c)) return;
      if (c == CH_LT) begin mode = M_AFTER_LT; return; end
      if (c == CH_GT) begin add_tok(K_GT, 0, 0, E_NONE); tag_open = 0; return; end
      if (c == CH_EQ) begin add_tok(K_EQ, 0, 0, E_NONE); return; end
      if (c == CH_SLASH) begin add_tok(K_SLASH, 0, 0, E_NONE); return; end
      if (c == CH_QUOTE) begin mode = M_STRING; return; end
      if (tag_open && is_alpha(c)) begin
         word = string'(c);
         word_long = 1'b0;
         mode = M_WORD;
         return;
      end
      add_tok(K_CHAR, c, 0, E_NONE);
   endfunction

   // closes the held word, returns 0 when it raised an error
   function automatic bit close_word();
      int hit;
      hit = -1;
      if (!word_long)
         for (int i = 0; i < 120; i++)
            if (hit < 0 && kw_names[i] == word) hit = i;
      if (hit < 0) begin
         halt_with(E_WORD);
         return 1'b0;
      end
      add_tok(K_KW, 0, 7'(hit), E_NONE);
      mode = M_NORMAL;
      return 1'b1;
   endfunction

   function automatic void close_doc();
      add_tok(K_EOF, 0, 0, E_NONE);
      mode = M_NORMAL;
      tag_open = 1'b0;
   endfunction

   function automatic void predict_tokens(logic [7:0] c, logic eoi);
      step_toks.delete();
      if (eoi) begin
         case (mode)
            M_HALT: ;
            M_AFTER_LT: begin
               add_tok(K_LT, 0, 0, E_NONE);
               close_doc();
            end
            M_WORD: if (close_word()) close_doc();
            M_STRING: halt_with(E_STRING);
            M_CMT0, M_CMT1, M_CMT2: halt_with(E_COMMENT);
            default: close_doc();
         endcase
      end else begin
         case (mode)
            M_HALT: ;
            M_AFTER_LT: begin
               if (c == CH_BANG) mode = M_CMT0;
               else begin
                  add_tok(K_LT, 0, 0, E_NONE);
                  tag_open = 1'b1;
                  mode = M_NORMAL;
                  lex_plain(c);
               end
            end
            M_WORD: begin
               if (is_alpha(c)) begin
                  if (word.len() < WORD_MAX) word = {word, string'(c)};
                  else word_long = 1'b1;
               end else if (close_word()) lex_plain(c);
            end
            M_STRING: begin
               if (c == CH_QUOTE) begin
                  add_tok(K_SEND, 0, 0, E_NONE);
                  mode = M_NORMAL;
               end else add_tok(K_SCHAR, c, 0, E_NONE);
            end
            M_CMT0: if (c == CH_DASH) mode = M_CMT1;
            M_CMT1: mode = (c == CH_DASH) ? M_CMT2 : M_CMT0;
            M_CMT2: mode = (c == CH_GT) ? M_NORMAL : M_CMT0;
            default: begin
               mode = M_NORMAL;
               lex_plain(c);
            end
         endcase
      end
      if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
      foreach (step_toks[i]) token_queue.push_back(step_toks[i]);
   endfunction

   function automatic void reset_model();
      mode = M_NORMAL;
      tag_open = 1'b0;
      word = "";
      word_long = 1'b0;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("mismatch token %0d %s: got %0d expected %0d", tokens_seen, what, got, want);
   endtask

   // sends one request, idling first at random; push stays high between requests unless it idles
   task automatic send_byte(logic [7:0] c, logic eoi);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      push <= 1'b1;
      req_input_byte <= c;
      req_end_of_input <= eoi;
      @(posedge clock);
      while (full) @(posedge clock);
      predict_tokens(c, eoi);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
   endtask

   task automatic end_doc();
      send_byte(8'($urandom), 1'b1);
   endtask

   // receiver: random stall bursts, checks each popped token
   initial begin
      int stall;
      token_type want;
      stall = 0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            stall--;
            pop <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 13) - 1;
            pop <= 1'b0;
         end else pop <= 1'b1;
         @(posedge clock);
         if (!reset && pop && !empty) begin
            if (token_queue.size() == 0) begin
               report("unexpected token kind", rsp_token_kind, 0);
            end else begin
               want = token_queue.pop_front();
               if (rsp_token_kind !== want.kind) report("kind", rsp_token_kind, want.kind);
               if (rsp_char_value !== want.ch) report("char", rsp_char_value, want.ch);
               if (rsp_keyword_index !== want.kw)
                  report("keyword", rsp_keyword_index, want.kw);
               if (rsp_error_code !== want.ec) report("error", rsp_error_code, want.ec);
               if (rsp_last_of_run !== want.last)
                  report("last", rsp_last_of_run, want.last);
            end
            tokens_seen++;
         end
      end
   end

   // reset is applied once; after an error the block stays halted until
   // reset, so tests avoid errors except at the very end
   task automatic test_directed();
      send_text("<html a=\"x");
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_text("\">");
      send_text("<!- --x-->");
      send_text("<!----->");
      send_text("< br/ >");
      send_byte(8'h00, 1'b0);
      send_text("<");
      send_byte(8'h00, 1'b0);
      end_doc();
      send_text("<referrerpolicy\t\r>");
      end_doc();
      send_text("<p");
      end_doc();
      send_text("<");
      end_doc();
   endtask

   function automatic string rand_word();
      string s;
      s = kw_names[$urandom_range(0, 119)];
      if (s == "h1") s = "hr";
      return s;
   endfunction

   // well-formed documents with random content
   task automatic test_documents(int count);
      int n;
      logic [7:0] c;
      repeat (count) begin
         n = $urandom_range(1, 6);
         repeat (n) begin
            case ($urandom_range(0, 4))
               0: begin
                  send_text({"<", rand_word()});
                  repeat ($urandom_range(0, 2)) begin
                     send_text({" ", rand_word(), "=\""});
                     repeat ($urandom_range(0, 4)) begin
                        c = 8'($urandom);
                        if (c == CH_QUOTE) c = 8'h80;
                        send_byte(c, 1'b0);
                     end
                     send_text("\"");
                  end
                  send_text($urandom_range(0, 1) ? "/>" : ">");
               end
               1: send_text({"</", rand_word(), ">"});
               2: send_text("<!-- a-b --->->-->");
               3: repeat ($urandom_range(1, 5)) begin
                  c = 8'($urandom);
                  if (c == CH_LT || c == CH_QUOTE) c = 8'h41;
                  send_byte(c, 1'b0);
               end
               default: send_text("<\x01>");
            endcase
         end
         end_doc();
      end
   endtask

   // error paths halt the block, so each ends the run
   task automatic test_error_halt();
      case ($urandom_range(0, 3))
         0: send_text("<abcdefghijklmnopq ");
         1: send_text("\"open");
         2: send_text("<zz>");
         default: send_text("<!-- never closed");
      endcase
      if ($urandom_range(0, 1)) end_doc();
      repeat (20) send_byte(8'($urandom), 1'($urandom));
   endtask

   initial begin
      int waited;
      reset_model();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_documents(28);
      idle_on = 1'b0;
      test_documents(7);
      test_error_halt();
      push <= 1'b0;
      waited = 0;
      while (token_queue.size() > 0 && waited < 10000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (token_queue.size() > 0) mismatches++;
      $display("sent %0d bytes and end marks, checked %0d tokens", items_sent, tokens_seen);
      if (mismatches == 0) $display("html_tag_lexer test passed");
      else $display("html_tag_lexer test failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("html_tag_lexer test failed");
      $finish;
   end
endmodule
`default_nettype wire

FILE: files.f
hdl/htl_pkg.sv
hdl/htl_front.sv
hdl/htl_back.sv
hdl/html_tag_lexer.sv
test/tb_top.sv
